[hw/rtl/mqf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared widths, codes and types of the message queue fragmenter.
// ----------------------------------------------------------------------------
package mqf_pkg;

  // field widths
  localparam int unsigned ID_W     = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned AVAIL_W  = 20;
  localparam int unsigned TOTAL_W  = 21;

  // a take stops after this many fragments
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS);

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SHORTFALL = 2'd2;

  // command classes produced by the front end
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_TAKE,
    CMD_TAKE_ZERO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   count;
  } cmd_t;

  // one queued message
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   remaining;
  } entry_t;

endpackage

[hw/rtl/mqf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_if
// Ready/valid channels for request beats and fragment result beats.
// ----------------------------------------------------------------------------
interface mqf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [mqf_pkg::ID_W-1:0]   message_id;
  logic [mqf_pkg::LEN_W-1:0]  byte_count;

  modport source (output valid, output operation, output message_id, output byte_count,
                  input ready);
  modport sink   (input valid, input operation, input message_id, input byte_count,
                  output ready);
endinterface

interface mqf_out_if;
  logic                          valid;
  logic                          ready;
  logic [mqf_pkg::ID_W-1:0]      fragment_id;
  logic [mqf_pkg::LEN_W-1:0]     fragment_length;
  logic                          more_fragments;
  logic                          last;
  logic [mqf_pkg::STATUS_W-1:0]  status;
  logic [mqf_pkg::AVAIL_W-1:0]   bytes_available;

  modport source (output valid, output fragment_id, output fragment_length,
                  output more_fragments, output last, output status,
                  output bytes_available, input ready);
  modport sink   (input valid, input fragment_id, input fragment_length,
                  input more_fragments, input last, input status,
                  input bytes_available, output ready);
endinterface

[hw/rtl/mqf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_front
// Accepts request beats and classifies them into push, take and empty take.
// ----------------------------------------------------------------------------
module mqf_front (
  mqf_in_if.sink          in_i,
  output logic            cmd_valid_o,
  output mqf_pkg::cmd_t   cmd_o,
  input  logic            cmd_ready_i
);

  // handshake passes straight to the command queue
  assign cmd_valid_o = in_i.valid;
  assign in_i.ready  = cmd_ready_i;

  // classify the beat
  always_comb begin
    cmd_o.id    = in_i.message_id;
    cmd_o.count = in_i.byte_count;
    if (in_i.operation == mqf_pkg::OP_PUSH) begin
      cmd_o.kind = mqf_pkg::CMD_PUSH;
    end else if (in_i.byte_count == '0) begin
      cmd_o.kind = mqf_pkg::CMD_TAKE_ZERO;
    end else begin
      cmd_o.kind = mqf_pkg::CMD_TAKE;
    end
  end

endmodule

[hw/rtl/mqf_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_cmd_fifo
// Two-entry command queue between front end and execution engine.
// ----------------------------------------------------------------------------
module mqf_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  mqf_pkg::cmd_t   wr_cmd_i,
  output logic            wr_ready_o,
  output logic            rd_valid_o,
  output mqf_pkg::cmd_t   rd_cmd_o,
  input  logic            rd_ready_i
);

  mqf_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    fill_q;
  logic          push;
  logic          pop;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_cmd_o   = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

[hw/rtl/mqf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_back
// Execution engine: message store, head/tail bookkeeping and fragment walk.
// ----------------------------------------------------------------------------
module mqf_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  mqf_pkg::cmd_t   cmd_i,
  output logic            cmd_ready_o,
  mqf_out_if.source       out_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [mqf_pkg::RES_CNT_W-1:0] LAST_RES =
    mqf_pkg::RES_CNT_W'(mqf_pkg::MAX_RESULTS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  // message store
  mqf_pkg::entry_t store_q [QUEUE_DEPTH];
  mqf_pkg::entry_t head_entry_q;
  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;
  mqf_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [IDX_W-1:0] mem_raddr;

  // control state
  state_e                          state_q, state_d;
  logic [IDX_W-1:0]                head_q, head_d;
  logic [IDX_W-1:0]                tail_q, tail_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [mqf_pkg::TOTAL_W-1:0]     total_q, total_d;
  logic [mqf_pkg::LEN_W-1:0]       budget_q, budget_d;
  logic [mqf_pkg::STATUS_W-1:0]    status_q, status_d;
  logic [mqf_pkg::RES_CNT_W-1:0]   nres_q, nres_d;

  // result register
  logic                            out_valid_q, out_valid_d;
  logic [mqf_pkg::ID_W-1:0]        out_id_q, out_id_d;
  logic [mqf_pkg::LEN_W-1:0]       out_len_q, out_len_d;
  logic                            out_more_q, out_more_d;
  logic                            out_last_q, out_last_d;
  logic [mqf_pkg::STATUS_W-1:0]    out_status_q, out_status_d;
  logic [mqf_pkg::AVAIL_W-1:0]     out_avail_q, out_avail_d;

  logic                            out_free;
  logic                            pop;
  logic                            load;
  logic [mqf_pkg::STATUS_W-1:0]    take_status;
  logic                            fits;
  logic [mqf_pkg::LEN_W-1:0]       budget_left;
  logic [IDX_W-1:0]                head_next;
  logic [IDX_W-1:0]                tail_next;
  logic                            walk_last;

  assign out_free    = !out_valid_q || out_o.ready;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // shortfall check against the running total
  assign take_status = ({{(mqf_pkg::TOTAL_W - mqf_pkg::LEN_W){1'b0}}, cmd_i.count} > total_q)
                       ? mqf_pkg::STATUS_SHORTFALL : mqf_pkg::STATUS_OK;

  // head entry decision
  assign fits        = (budget_q >= head_entry_q.remaining);
  assign budget_left = budget_q - head_entry_q.remaining;
  assign head_next   = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
  assign tail_next   = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
  assign walk_last   = !fits || (budget_left == '0) || (count_q == CNT_W'(1)) ||
                       (nres_q == LAST_RES);

  // next-state logic
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    total_d      = total_q;
    budget_d     = budget_q;
    status_d     = status_q;
    nres_d       = nres_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_id_d     = out_id_q;
    out_len_d    = out_len_q;
    out_more_d   = out_more_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    out_avail_d  = out_avail_q;
    load         = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = tail_q;
    mem_wdata    = '{id: cmd_i.id, remaining: cmd_i.count};
    mem_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          out_id_d   = '0;
          out_len_d  = '0;
          out_more_d = 1'b0;
          out_last_d = 1'b1;
          unique case (cmd_i.kind)
            mqf_pkg::CMD_PUSH: begin
              load = 1'b1;
              if (count_q == FULL_CNT) begin
                out_status_d = mqf_pkg::STATUS_PUSH_FULL;
              end else begin
                mem_we       = 1'b1;
                tail_d       = tail_next;
                count_d      = count_q + CNT_W'(1);
                total_d      = total_q + mqf_pkg::TOTAL_W'(cmd_i.count);
                out_status_d = mqf_pkg::STATUS_OK;
              end
            end
            mqf_pkg::CMD_TAKE_ZERO: begin
              load         = 1'b1;
              out_status_d = take_status;
            end
            mqf_pkg::CMD_TAKE: begin
              if (count_q == '0) begin
                load         = 1'b1;
                out_status_d = take_status;
              end else begin
                // fetch the head entry and start the walk
                mem_re   = 1'b1;
                budget_d = cmd_i.count;
                status_d = take_status;
                nres_d   = '0;
                state_d  = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (out_free) begin
          load         = 1'b1;
          out_id_d     = head_entry_q.id;
          out_status_d = status_q;
          out_last_d   = walk_last;
          nres_d       = nres_q + mqf_pkg::RES_CNT_W'(1);
          if (fits) begin
            // whole message leaves the queue
            out_len_d  = head_entry_q.remaining;
            out_more_d = 1'b0;
            head_d     = head_next;
            count_d    = count_q - CNT_W'(1);
            total_d    = total_q - mqf_pkg::TOTAL_W'(head_entry_q.remaining);
            budget_d   = budget_left;
            if (walk_last) begin
              state_d = ST_IDLE;
            end else begin
              mem_re = 1'b1;
            end
          end else begin
            // partial fragment, remainder written back
            out_len_d  = budget_q;
            out_more_d = 1'b1;
            mem_we     = 1'b1;
            mem_waddr  = head_q;
            mem_wdata  = '{id: head_entry_q.id,
                           remaining: head_entry_q.remaining - budget_q};
            total_d    = total_q - mqf_pkg::TOTAL_W'(budget_q);
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
      out_avail_d = total_d[mqf_pkg::AVAIL_W-1:0];
    end
  end

  assign mem_raddr = head_d;

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      total_q      <= '0;
      budget_q     <= '0;
      status_q     <= mqf_pkg::STATUS_OK;
      nres_q       <= '0;
      out_valid_q  <= 1'b0;
      out_id_q     <= '0;
      out_len_q    <= '0;
      out_more_q   <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= mqf_pkg::STATUS_OK;
      out_avail_q  <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      total_q      <= total_d;
      budget_q     <= budget_d;
      status_q     <= status_d;
      nres_q       <= nres_d;
      out_valid_q  <= out_valid_d;
      out_id_q     <= out_id_d;
      out_len_q    <= out_len_d;
      out_more_q   <= out_more_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      out_avail_q  <= out_avail_d;
    end
  end

  // message store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      head_entry_q <= store_q[mem_raddr];
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.fragment_id     = out_id_q;
  assign out_o.fragment_length = out_len_q;
  assign out_o.more_fragments  = out_more_q;
  assign out_o.last            = out_last_q;
  assign out_o.status          = out_status_q;
  assign out_o.bytes_available = out_avail_q;

  // occupancy never exceeds the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count beyond queue depth");

  // a walk only runs over a non-empty queue with budget left
  a_walk_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> (count_q != '0) && (budget_q != '0))
    else $error("walk on empty queue or spent budget");

  // a partial fragment always closes the result sequence
  a_more_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_more_q |-> out_last_q)
    else $error("partial fragment without last");

  // a dropped push leaves the queue full
  a_drop_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (cmd_i.kind == mqf_pkg::CMD_PUSH) && (count_q == FULL_CNT)
    |=> (count_q == FULL_CNT) && $stable(tail_q))
    else $error("dropped push changed the queue");

endmodule

[hw/rtl/message_queue_fragmenter.sv]
`timescale 1ns / 1ps
// Path: a push result passes the command queue and the result register; a take shows
//   its first fragment after the command queue, head read and result reg.
// Throughput: one push per cycle while results are taken; during a take the engine
//   accepts no command and walks the store from the head through its single read port.
// Reset: control state clears at once; store contents stay undefined until written,
//   with no clearing pass, so the block takes beats right after reset.
// ----------------------------------------------------------------------------
// message_queue_fragmenter
// FIFO of messages that hands out byte budgets as per-message fragments.
// ----------------------------------------------------------------------------
module message_queue_fragmenter #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mqf_in_if.sink      in_i,
  mqf_out_if.source   out_o
);

  logic          fe_valid;
  mqf_pkg::cmd_t fe_cmd;
  logic          fe_ready;
  logic          be_valid;
  mqf_pkg::cmd_t be_cmd;
  logic          be_ready;

  // front end: accept and classify
  mqf_front u_front (
    .in_i        (in_i),
    .cmd_valid_o (fe_valid),
    .cmd_o       (fe_cmd),
    .cmd_ready_i (fe_ready)
  );

  // decoupling queue
  mqf_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_cmd_i   (fe_cmd),
    .wr_ready_o (fe_ready),
    .rd_valid_o (be_valid),
    .rd_cmd_o   (be_cmd),
    .rd_ready_i (be_ready)
  );

  // back end: store and fragment walk
  mqf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_i       (be_cmd),
    .cmd_ready_o (be_ready),
    .out_o       (out_o)
  );

endmodule
